[rtl/kevq_pkg.sv]
`timescale 1ns / 1ps

package kevq_pkg;

  // default sizing
  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned TimeWidthDefault  = 32;

  // fixed field widths
  localparam int unsigned KeyWidth     = 3;
  localparam int unsigned FuncWidth    = 2;
  localparam int unsigned NowWidth     = 32;
  localparam int unsigned WindowWidth  = 16;
  localparam int unsigned RunWidth     = 10;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;

  // register reset values
  localparam logic [WindowWidth-1:0] RepeatWindowReset = 16'd30;
  localparam logic [RunWidth-1:0]    HoldCountReset    = 10'd250;

  // buttons up, left, ok, right, down, cancel
  localparam logic [KeyWidth-1:0] NumKeys = 3'd6;
  localparam logic [RunWidth-1:0] RunMax  = 10'd1023;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] RegRepeatWindow = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegHoldCount    = 2'd1;

  typedef logic [KeyWidth-1:0] key_t;

  typedef enum logic [FuncWidth-1:0] {
    FUNC_KEY_EDGE = 2'd0,
    FUNC_READ     = 2'd1,
    FUNC_POWER    = 2'd2,
    FUNC_NONE     = 2'd3
  } func_e;

  // ring request from the control stage
  typedef struct packed {
    logic push;
    logic pop;
    key_t key;
  } ring_ctrl_t;

  // ring status back to the control stage
  typedef struct packed {
    logic full;
    logic empty;
    key_t key;
  } ring_stat_t;

endpackage

[rtl/kevq_ring.sv]
`timescale 1ns / 1ps

module kevq_ring import kevq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ring_ctrl_t ctrl_i,
  output ring_stat_t stat_o
);

  localparam int unsigned PtrWidth = $clog2(QUEUE_DEPTH);
  localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(QUEUE_DEPTH - 1);

  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrWidth-1:0] wr_ptr_nxt, rd_ptr_nxt;
  key_t                store_q [QUEUE_DEPTH];

  // pointer increment with wrap at the last slot
  assign wr_ptr_nxt = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;

  assign wr_ptr_d = ctrl_i.push ? wr_ptr_nxt : wr_ptr_q;
  assign rd_ptr_d = ctrl_i.pop  ? rd_ptr_nxt : rd_ptr_q;

  // one slot stays open so full and empty differ
  assign stat_o.full  = (wr_ptr_nxt == rd_ptr_q);
  assign stat_o.empty = (wr_ptr_q == rd_ptr_q);
  assign stat_o.key   = store_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // slot storage, no reset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      store_q[wr_ptr_q] <= ctrl_i.key;
    end
  end

endmodule

[rtl/kevq_power.sv]
`timescale 1ns / 1ps

module kevq_power import kevq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sample_i,
  input  logic                level_i,
  input  logic [RunWidth-1:0] hold_count_i,
  output logic                halt_d_o,
  output logic                halt_q_o
);

  logic [RunWidth-1:0] run_q, run_d, run_inc;
  logic                halt_q, halt_d;

  // saturating run of high samples
  assign run_inc = (run_q == RunMax) ? run_q : run_q + 1'b1;

  always_comb begin
    run_d  = run_q;
    halt_d = halt_q;
    if (sample_i) begin
      if (level_i) begin
        run_d = run_inc;
        if (run_inc >= hold_count_i) begin
          halt_d = 1'b1;
        end
      end else begin
        run_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      halt_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      halt_q <= halt_d;
    end
  end

  assign halt_d_o = halt_d;
  assign halt_q_o = halt_q;

endmodule

[rtl/keypad_event_queue_debounce_core.sv]
`timescale 1ns / 1ps

// channel  direction  handshake                    payload
// in       in         in_valid_i / in_ready_o      in_func_i, in_key_index_i, in_pin_level_i,
//                                                  in_now_ticks_i
// out      out        out_valid_o / out_ready_i    out_key_valid_o, out_key_out_o,
//                                                  out_queue_empty_o, out_repeat_dropped_o,
//                                                  out_overflow_o, out_halt_o
// cfg      in         cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// an item is captured in the input register, worked by the single pass of queue, repeat and
// power logic and its result lands in the output register; one item per cycle is sustained
// while the output is not stalled.
// reset clears pointers, repeat tracking, run counter and halt; queue slots are not cleared.
// a stalled output holds the input register, and in_ready_o drops only then.
// configuration writes are always taken.

module keypad_event_queue_debounce_core import kevq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  parameter int unsigned TIME_WIDTH  = TimeWidthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [FuncWidth-1:0]    in_func_i,
  input  logic [KeyWidth-1:0]     in_key_index_i,
  input  logic                    in_pin_level_i,
  input  logic [NowWidth-1:0]     in_now_ticks_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    out_key_valid_o,
  output logic [KeyWidth-1:0]     out_key_out_o,
  output logic                    out_queue_empty_o,
  output logic                    out_repeat_dropped_o,
  output logic                    out_overflow_o,
  output logic                    out_halt_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i
);

  localparam int unsigned NowUsed = (TIME_WIDTH < NowWidth) ? TIME_WIDTH : NowWidth;

  // configuration registers
  logic [WindowWidth-1:0] repeat_window_q;
  logic [RunWidth-1:0]    hold_count_q;

  // input register
  logic                  s1_valid_q;
  func_e                 s1_func_q;
  key_t                  s1_key_q;
  logic                  s1_level_q;
  logic [TIME_WIDTH-1:0] s1_now_q;

  // repeat tracking
  key_t                  last_key_q;
  logic                  last_valid_q;
  logic [TIME_WIDTH-1:0] last_time_q;

  // result register
  logic out_valid_q;
  logic key_valid_q, queue_empty_q, repeat_q, overflow_q, halt_out_q;
  key_t key_out_q;

  logic                  advance;
  logic                  is_press, is_repeat, is_read, push_ok;
  logic [TIME_WIDTH-1:0] diff;
  ring_ctrl_t            ring_ctrl;
  ring_stat_t            ring_stat;
  logic                  halt_d, halt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_window_q <= RepeatWindowReset;
      hold_count_q    <= HoldCountReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegRepeatWindow: repeat_window_q <= cfg_data_i[WindowWidth-1:0];
        RegHoldCount:    hold_count_q    <= cfg_data_i[RunWidth-1:0];
        default:         ;
      endcase
    end
  end

  // pipeline flow
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_func_q  <= func_e'(in_func_i);
      s1_key_q   <= in_key_index_i;
      s1_level_q <= in_pin_level_i;
      s1_now_q   <= TIME_WIDTH'(in_now_ticks_i[NowUsed-1:0]);
    end
  end

  // key edge decode and repeat window test
  assign diff      = s1_now_q - last_time_q;
  assign is_press  = (s1_func_q == FUNC_KEY_EDGE) && !s1_level_q && (s1_key_q < NumKeys);
  assign is_repeat = is_press && last_valid_q && (s1_key_q == last_key_q) &&
                     (diff < TIME_WIDTH'(repeat_window_q));
  assign push_ok   = is_press && !is_repeat && !ring_stat.full;
  assign is_read   = (s1_func_q == FUNC_READ);

  assign ring_ctrl.push = advance && push_ok;
  assign ring_ctrl.pop  = advance && is_read && !ring_stat.empty;
  assign ring_ctrl.key  = s1_key_q;

  kevq_ring #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ring (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(ring_ctrl),
    .stat_o(ring_stat)
  );

  kevq_power u_power (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (advance && (s1_func_q == FUNC_POWER)),
    .level_i     (s1_level_q),
    .hold_count_i(hold_count_q),
    .halt_d_o    (halt_d),
    .halt_q_o    (halt_q)
  );

  // last queued key, kept even after it is popped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_key_q   <= '0;
      last_valid_q <= 1'b0;
      last_time_q  <= '0;
    end else if (ring_ctrl.push) begin
      last_key_q   <= s1_key_q;
      last_valid_q <= 1'b1;
      last_time_q  <= s1_now_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      key_valid_q   <= is_read && !ring_stat.empty;
      key_out_q     <= (is_read && !ring_stat.empty) ? ring_stat.key : '0;
      queue_empty_q <= is_read && ring_stat.empty;
      repeat_q      <= is_repeat;
      overflow_q    <= is_press && !is_repeat && ring_stat.full;
      halt_out_q    <= halt_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_key_valid_o      = key_valid_q;
  assign out_key_out_o        = key_out_q;
  assign out_queue_empty_o    = queue_empty_q;
  assign out_repeat_dropped_o = repeat_q;
  assign out_overflow_o       = overflow_q;
  assign out_halt_o           = halt_out_q;

  // at most one outcome flag per result
  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({out_key_valid_o, out_queue_empty_o,
                              out_repeat_dropped_o, out_overflow_o}))
    else $error("more than one outcome flag in a result");

  // halt never falls once raised
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt cleared without reset");

  // popped key is zero unless a key was returned
  a_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_key_valid_o) |-> (out_key_out_o == '0))
    else $error("key_out set without key_valid");

  // input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while output free");

endmodule

[tb/sv/keypad_event_queue_debounce_core_tb.sv]
`timescale 1ns / 1ps

module keypad_event_queue_debounce_core_tb;
  import kevq_pkg::*;

  localparam int unsigned Depth   = QueueDepthDefault;
  localparam int unsigned PtrBits = $clog2(Depth);

  typedef struct packed {
    func_e                func;
    key_t                 key;
    logic                 level;
    logic [NowWidth-1:0]  now;
  } item_t;

  typedef struct packed {
    logic popped;
    key_t key;
    logic empty;
    logic suppressed;
    logic full_drop;
    logic halt;
  } outcome_t;

  logic                    clk = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [FuncWidth-1:0]    in_func_i;
  logic [KeyWidth-1:0]     in_key_index_i;
  logic                    in_pin_level_i;
  logic [NowWidth-1:0]     in_now_ticks_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    out_key_valid_o;
  logic [KeyWidth-1:0]     out_key_out_o;
  logic                    out_queue_empty_o;
  logic                    out_repeat_dropped_o;
  logic                    out_overflow_o;
  logic                    out_halt_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CfgIdxWidth-1:0]  cfg_index_i;
  logic [CfgDataWidth-1:0] cfg_data_i;

  keypad_event_queue_debounce_core uut (
    .clk_i                (clk),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .in_func_i            (in_func_i),
    .in_key_index_i       (in_key_index_i),
    .in_pin_level_i       (in_pin_level_i),
    .in_now_ticks_i       (in_now_ticks_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .out_key_valid_o      (out_key_valid_o),
    .out_key_out_o        (out_key_out_o),
    .out_queue_empty_o    (out_queue_empty_o),
    .out_repeat_dropped_o (out_repeat_dropped_o),
    .out_overflow_o       (out_overflow_o),
    .out_halt_o           (out_halt_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // key queue shadow and power-hold tracking
  key_t                  ring [Depth];
  logic [PtrBits-1:0]    wr_ptr;
  logic [PtrBits-1:0]    rd_ptr;
  key_t                  last_key;
  logic                  last_ok;
  logic [NowWidth-1:0]   last_stamp;
  logic [RunWidth-1:0]   run_len;
  logic                  halted;
  logic [WindowWidth-1:0] window_reg;
  logic [RunWidth-1:0]   hold_reg;

  item_t    pending [$];
  outcome_t expected [$];

  logic        in_acc;
  logic        out_acc;
  int unsigned tx_wait;
  int unsigned rx_wait;
  logic        tx_burst;
  logic        rx_burst;
  item_t       tx_item;

  int unsigned errors;
  int unsigned n_items;
  int unsigned results_seen;
  int unsigned n_pops;
  int unsigned n_empty;
  int unsigned n_suppressed;
  int unsigned n_full;
  int unsigned n_long_holds;

  // stimulus generator state
  logic [NowWidth-1:0] tick;
  key_t                prev_key;
  int unsigned         hi_run;

  // one mismatch line per call
  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    errors++;
    $display("error at %0t ns: %s expected %0d got %0d", $time, what, want, got);
  endtask

  // work out the result of one item and advance the shadow state
  task automatic run_keypad(input item_t it, output outcome_t res);
    logic [NowWidth-1:0] age;
    logic [PtrBits-1:0]  nxt;
    res = '0;
    case (it.func)
      FUNC_KEY_EDGE: begin
        if (!it.level && it.key < NumKeys) begin
          age = it.now - last_stamp;
          nxt = wr_ptr + 1'b1;
          if (last_ok && it.key == last_key && age < window_reg) begin
            res.suppressed = 1'b1;
          end else if (nxt == rd_ptr) begin
            res.full_drop = 1'b1;
          end else begin
            ring[wr_ptr] = it.key;
            wr_ptr = nxt;
            last_key = it.key;
            last_ok = 1'b1;
            last_stamp = it.now;
          end
        end
      end
      FUNC_READ: begin
        if (wr_ptr == rd_ptr) begin
          res.empty = 1'b1;
        end else begin
          res.popped = 1'b1;
          res.key = ring[rd_ptr];
          rd_ptr = rd_ptr + 1'b1;
        end
      end
      FUNC_POWER: begin
        if (it.level) begin
          if (run_len != RunMax) run_len = run_len + 1'b1;
          if (run_len >= hold_reg) halted = 1'b1;
        end else begin
          run_len = '0;
        end
      end
      default: ;
    endcase
    res.halt = halted;
  endtask

  // accept side: shadow config, predict, and compare results
  always @(posedge clk) begin : monitor
    item_t    it;
    outcome_t want;
    outcome_t got;
    if (rst_ni) begin
      in_acc  <= in_valid_i && in_ready_o;
      out_acc <= out_valid_o && out_ready_i;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegRepeatWindow: window_reg = cfg_data_i[WindowWidth-1:0];
          RegHoldCount:    hold_reg   = cfg_data_i[RunWidth-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        it.func  = func_e'(in_func_i);
        it.key   = in_key_index_i;
        it.level = in_pin_level_i;
        it.now   = in_now_ticks_i;
        run_keypad(it, want);
        expected.push_back(want);
        n_items++;
      end
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        got.popped     = out_key_valid_o;
        got.key        = out_key_out_o;
        got.empty      = out_queue_empty_o;
        got.suppressed = out_repeat_dropped_o;
        got.full_drop  = out_overflow_o;
        got.halt       = out_halt_o;
        if (expected.size() == 0) begin
          flag_mismatch("result with nothing pending", 0, 1);
        end else begin
          want = expected.pop_front();
          if (got.popped !== want.popped) flag_mismatch("key_valid", want.popped, got.popped);
          if (got.key !== want.key) flag_mismatch("key_out", want.key, got.key);
          if (got.empty !== want.empty) flag_mismatch("queue_empty", want.empty, got.empty);
          if (got.suppressed !== want.suppressed)
            flag_mismatch("repeat_dropped", want.suppressed, got.suppressed);
          if (got.full_drop !== want.full_drop)
            flag_mismatch("overflow", want.full_drop, got.full_drop);
          if (got.halt !== want.halt) flag_mismatch("halt", want.halt, got.halt);
          n_pops       += want.popped;
          n_empty      += want.empty;
          n_suppressed += want.suppressed;
          n_full       += want.full_drop;
        end
      end
    end else begin
      in_acc  <= 1'b0;
      out_acc <= 1'b0;
    end
  end

  // sender: holds the item until taken, then waits a random gap
  always @(negedge clk) begin
    if (rst_ni && !(in_valid_i && !in_acc)) begin
      if (in_acc) begin
        if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
        tx_wait = tx_burst ? 0 : $urandom_range(0, 13);
      end
      if (tx_wait != 0) begin
        in_valid_i <= 1'b0;
        tx_wait--;
      end else if (pending.size() != 0) begin
        tx_item = pending.pop_front();
        in_func_i      <= tx_item.func;
        in_key_index_i <= tx_item.key;
        in_pin_level_i <= tx_item.level;
        in_now_ticks_i <= tx_item.now;
        in_valid_i     <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stall per item, plus long holds to back up the input
  always @(negedge clk) begin
    if (rst_ni) begin
      if (out_acc) begin
        if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
        if (results_seen == 150 || results_seen == 700) begin
          rx_wait = 60;
          n_long_holds++;
        end else begin
          rx_wait = rx_burst ? 0 : $urandom_range(0, 13);
        end
      end
      if (rx_wait != 0) begin
        out_ready_i <= 1'b0;
        rx_wait--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic item_t mk(input func_e f, input key_t k, input logic lv,
                               input logic [NowWidth-1:0] t);
    mk.func  = f;
    mk.key   = k;
    mk.level = lv;
    mk.now   = t;
  endfunction

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] val);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  // wait until every item is taken and every result is back
  task automatic wait_drained();
    @(posedge clk);
    while (pending.size() != 0 || in_valid_i || expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // random mix: key edges with repeats of the last key, reads, power samples
  task automatic gen_items(input int unsigned target, input int unsigned span,
                           input int unsigned read_pct, input int unsigned high_pct,
                           input int unsigned high_cap);
    int unsigned counted;
    int unsigned pick;
    item_t       it;
    counted = 0;
    while (counted < target) begin
      it.key   = key_t'($urandom_range(0, 7));
      it.level = 1'($urandom_range(0, 1));
      it.now   = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        it.func = FUNC_NONE;
      end else if (pick < 4 + read_pct) begin
        it.func = FUNC_READ;
      end else if (pick < 22 + read_pct) begin
        it.func  = FUNC_POWER;
        it.level = (hi_run < high_cap) && ($urandom_range(0, 99) < high_pct);
        hi_run   = it.level ? hi_run + 1 : 0;
      end else begin
        it.func  = FUNC_KEY_EDGE;
        it.level = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 19) == 0) it.key = key_t'($urandom_range(6, 7));
        else if ($urandom_range(0, 99) < 45) it.key = prev_key;
        else it.key = key_t'($urandom_range(0, 5));
        if ($urandom_range(0, 29) == 0) tick = $urandom;
        else tick = tick + $urandom_range(0, span);
        it.now = tick;
        if (!it.level && it.key < NumKeys) begin
          prev_key = it.key;
        end
      end
      pending.push_back(it);
      counted++;
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_func_i      = FUNC_NONE;
    in_key_index_i = '0;
    in_pin_level_i = 1'b1;
    in_now_ticks_i = '0;
    out_ready_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = RegRepeatWindow;
    cfg_data_i     = '0;
    in_acc = 1'b0;
    out_acc = 1'b0;
    tx_wait = 0;
    rx_wait = 0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    errors = 0;
    n_items = 0;
    results_seen = 0;
    n_pops = 0;
    n_empty = 0;
    n_suppressed = 0;
    n_full = 0;
    n_long_holds = 0;
    wr_ptr = '0;
    rd_ptr = '0;
    last_key = '0;
    last_ok = 1'b0;
    last_stamp = '0;
    run_len = '0;
    halted = 1'b0;
    window_reg = RepeatWindowReset;
    hold_reg = HoldCountReset;
    tick = '0;
    prev_key = '0;
    hi_run = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // directed part on reset register values
    pending.push_back(mk(FUNC_READ, 3'd0, 1'b0, 32'd0));        // read of empty queue
    pending.push_back(mk(FUNC_KEY_EDGE, 3'd0, 1'b0, 32'd0));
    pending.push_back(mk(FUNC_KEY_EDGE, 3'd0, 1'b0, 32'd29));   // repeat just inside window
    pending.push_back(mk(FUNC_KEY_EDGE, 3'd0, 1'b1, 32'd29));   // release edge
    pending.push_back(mk(FUNC_KEY_EDGE, 3'd6, 1'b0, 32'd35));   // unknown buttons
    pending.push_back(mk(FUNC_KEY_EDGE, 3'd7, 1'b0, 32'd36));
    pending.push_back(mk(FUNC_KEY_EDGE, 3'd5, 1'b0, 32'd40));
    pending.push_back(mk(FUNC_KEY_EDGE, 3'd5, 1'b0, 32'd70));   // repeat exactly at window
    for (int i = 0; i < 12; i++)
      pending.push_back(mk(FUNC_KEY_EDGE, key_t'(1 + i % 4), 1'b0, 32'd100 + i));
    pending.push_back(mk(FUNC_KEY_EDGE, 3'd2, 1'b0, 32'd200));  // queue full
    pending.push_back(mk(FUNC_KEY_EDGE, 3'd4, 1'b0, 32'd115));  // repeat wins over full
    pending.push_back(mk(FUNC_READ, 3'd7, 1'b1, 32'hFFFF_FFFF));
    pending.push_back(mk(FUNC_NONE, 3'd7, 1'b1, 32'hFFFF_FFFF));
    pending.push_back(mk(FUNC_POWER, 3'd0, 1'b1, 32'd0));
    pending.push_back(mk(FUNC_POWER, 3'd0, 1'b0, 32'd0));
    pending.push_back(mk(FUNC_POWER, 3'd0, 1'b1, 32'd0));
    pending.push_back(mk(FUNC_KEY_EDGE, 3'd3, 1'b0, 32'hFFFF_FFFF));
    prev_key = 3'd3;
    tick = 32'd300;
    wait_drained();

    // no repeat window, highest hold count
    write_reg(RegRepeatWindow, 16'd0);
    write_reg(RegHoldCount, 16'd1023);
    gen_items(200, 40, 30, 60, 300);
    wait_drained();

    // widest window, ticks wrapping through zero
    write_reg(RegRepeatWindow, 16'hFFFF);
    tick = 32'hFFFF_F000;
    gen_items(250, 20000, 20, 50, 300);
    wait_drained();

    // random window, few reads so the queue stays full
    write_reg(RegRepeatWindow, CfgDataWidth'($urandom_range(1, 200)));
    gen_items(250, 150, 8, 50, 300);
    pending.push_back(mk(FUNC_POWER, 3'd0, 1'b0, 32'd0));
    for (int i = 0; i < 100; i++)
      pending.push_back(mk(FUNC_POWER, key_t'($urandom), 1'b1, $urandom));
    wait_drained();

    // the run carries over the write and hits the new count exactly
    write_reg(RegHoldCount, 16'd101);
    write_reg(RegRepeatWindow, 16'd30);
    pending.push_back(mk(FUNC_POWER, 3'd0, 1'b1, 32'd0));
    hi_run = 0;
    gen_items(200, 60, 35, 70, 1000);
    wait_drained();

    // zero hold count
    write_reg(RegHoldCount, 16'd0);
    write_reg(RegRepeatWindow, CfgDataWidth'($urandom_range(1, 65534)));
    gen_items(150, 30000, 30, 50, 1000);
    wait_drained();

    $display("covered %0d items and %0d results: %0d pops, %0d empty reads",
             n_items, results_seen, n_pops, n_empty);
    $display("%0d repeats suppressed, %0d full-queue drops, halt %0d, %0d long output holds",
             n_suppressed, n_full, halted, n_long_holds);
    if (errors == 0) begin
      $display("keypad_event_queue_debounce_core: match");
    end else begin
      $display("keypad_event_queue_debounce_core: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("keypad_event_queue_debounce_core: mismatch");
    $finish;
  end

endmodule

[keypad_event_queue_debounce_core.f]
rtl/kevq_pkg.sv
rtl/kevq_ring.sv
rtl/kevq_power.sv
rtl/keypad_event_queue_debounce_core.sv
tb/sv/keypad_event_queue_debounce_core_tb.sv
